>>> rtl/core/idc_pkg.sv
// idc_pkg: shared types and constants for the inversion disorder classifier
// used by idc_store, idc_div and inversion_disorder_classifier
`timescale 1ns / 1ps

package idc_pkg;

    localparam int VALUE_W   = 32;
    localparam int CNT_OUT_W = 19;
    localparam int QUO_W     = 17;
    localparam int CLASS_W   = 2;
    localparam int STEP_W    = $clog2(QUO_W + 1);

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      is_last;
    } item_word_t;

    typedef struct packed {
        logic [CNT_OUT_W-1:0] inversion_count;
        logic [CNT_OUT_W-1:0] pair_count;
        logic [QUO_W-1:0]     disorder_q16;
        logic [CLASS_W-1:0]   disorder_class;
        logic                 overflowed;
    } result_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_STORE,
        ST_MUL,
        ST_CLASS,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef enum logic [CLASS_W-1:0] {
        CLASS_LOW  = 2'd0,
        CLASS_MID  = 2'd1,
        CLASS_HIGH = 2'd2
    } class_t;

endpackage

>>> rtl/core/inversion_disorder_classifier.sv
// inversion_disorder_classifier: counts inversions over a list and grades its disorder
// an item that finds k stored words reads them one store read per cycle, then is written to the store
// the final word of a list then goes through multiply, class, 17 divide steps (none when no pairs), output
// throughput: one item at a time, stall is high until the current item is finished
// reset clears the list count, totals, sequencer and output valid; the store is not cleared
// depends on idc_pkg, idc_store, idc_div
`timescale 1ns / 1ps

module inversion_disorder_classifier
    import idc_pkg::*;
#(
    parameter int MAX_N = 1024
)(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_stall,
    input  item_word_t   item,
    output logic         result_valid,
    input  logic         result_stall,
    output result_word_t result
);

    localparam int CNT_W  = $clog2(MAX_N + 1);
    localparam int ADDR_W = $clog2(MAX_N);
    localparam int PROD_W = 2 * CNT_W;
    localparam int FIVE_W = PROD_W + 3;

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [ADDR_W-1:0]         idx_reg, idx_next;
    logic signed [VALUE_W-1:0] value_reg, value_next;
    logic                      last_reg, last_next;
    logic [PROD_W-1:0]         inv_reg, inv_next;
    logic                      ovf_reg, ovf_next;
    logic                      rd_valid_reg, rd_valid_next;
    logic [PROD_W-1:0]         prod_reg, prod_next;
    logic [PROD_W-1:0]         pairs_reg, pairs_next;
    class_t                    class_reg, class_next;
    result_word_t              result_reg, result_next;
    logic                      result_valid_reg, result_valid_next;

    logic                      rd_en, wr_en, div_start, div_done, hit;
    logic [VALUE_W-1:0]        rd_data;
    logic [QUO_W-1:0]          div_quo;
    logic [PROD_W-1:0]         pairs;
    logic [FIVE_W-1:0]         five_inv;

    idc_store #(
        .DEPTH  (MAX_N),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (value_reg),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    idc_div #(
        .W (PROD_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (inv_reg),
        .den   (pairs),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            inv_reg          <= '0;
            ovf_reg          <= 1'b0;
            rd_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            inv_reg          <= inv_next;
            ovf_reg          <= ovf_next;
            rd_valid_reg     <= rd_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        value_reg  <= value_next;
        last_reg   <= last_next;
        prod_reg   <= prod_next;
        pairs_reg  <= pairs_next;
        class_reg  <= class_next;
        result_reg <= result_next;
    end

    // the shared compare: one stored word against the current word per cycle
    assign hit      = rd_valid_reg && ($signed(rd_data) > value_reg);
    assign pairs    = prod_reg >> 1;
    assign five_inv = FIVE_W'({inv_reg, 2'b00}) + FIVE_W'(inv_reg);

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        idx_next          = idx_reg;
        value_next        = value_reg;
        last_next         = last_reg;
        inv_next          = inv_reg + PROD_W'(hit);
        ovf_next          = ovf_reg;
        rd_valid_next     = 1'b0;
        prod_next         = prod_reg;
        pairs_next        = pairs_reg;
        class_next        = class_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        rd_en             = 1'b0;
        wr_en             = 1'b0;
        div_start         = 1'b0;

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    value_next = item.value;
                    last_next  = item.is_last;
                    idx_next   = '0;
                    if (count_reg == CNT_W'(MAX_N))
                    begin
                        // store full: word dropped, list end still honored
                        ovf_next   = 1'b1;
                        state_next = item.is_last ? ST_MUL : ST_IDLE;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = ST_STORE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                rd_en         = 1'b1;
                rd_valid_next = 1'b1;
                idx_next      = idx_reg + ADDR_W'(1);
                if (CNT_W'(idx_reg) + CNT_W'(1) == count_reg)
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                // last read data is compared in this cycle too
                wr_en      = 1'b1;
                count_next = count_reg + CNT_W'(1);
                state_next = last_reg ? ST_MUL : ST_IDLE;
            end
            ST_MUL:
            begin
                prod_next  = PROD_W'(count_reg) * PROD_W'(count_reg - CNT_W'(1));
                state_next = ST_CLASS;
            end
            ST_CLASS:
            begin
                pairs_next = pairs;
                if (pairs == '0)
                begin
                    class_next = CLASS_LOW;
                    state_next = ST_OUT;
                end
                else
                begin
                    if (five_inv < FIVE_W'(pairs))
                    begin
                        class_next = CLASS_LOW;
                    end
                    else if ({inv_reg, 1'b0} < {1'b0, pairs})
                    begin
                        class_next = CLASS_MID;
                    end
                    else
                    begin
                        class_next = CLASS_HIGH;
                    end
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_next.inversion_count = CNT_OUT_W'(inv_reg);
                    result_next.pair_count      = CNT_OUT_W'(pairs_reg);
                    result_next.disorder_q16    = (pairs_reg == '0) ? '0 : div_quo;
                    result_next.disorder_class  = class_reg;
                    result_next.overflowed      = ovf_reg;
                    result_valid_next           = 1'b1;
                    count_next                  = '0;
                    inv_next                    = '0;
                    ovf_next                    = 1'b0;
                    state_next                  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_N))
        else $error("list count beyond store depth");

    a_store_advances: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_STORE |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("store cycle did not advance the count");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the output step");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished while sequencer not waiting");

endmodule

>>> rtl/core/idc_store.sv
// idc_store: single-port-write, single-port-read value memory with registered read
// depends on idc_pkg for the value width
`timescale 1ns / 1ps

module idc_store
    import idc_pkg::*;
#(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
)(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  logic [VALUE_W-1:0] wr_data,
    input  logic               rd_en,
    input  logic [ADDR_W-1:0]  rd_addr,
    output logic [VALUE_W-1:0] rd_data
);

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/idc_div.sv
// idc_div: restoring divider, one quotient bit per cycle, for num <= den
// depends on idc_pkg for the quotient width
`timescale 1ns / 1ps

module idc_div
    import idc_pkg::*;
#(
    parameter int W = 22
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [W-1:0]     num,
    input  logic [W-1:0]     den,
    output logic             done,
    output logic [QUO_W-1:0] quo
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [W:0]        rem_reg, rem_next;
    logic [W-1:0]      den_reg, den_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [W:0]        trial;
    logic              ge;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    // first step takes the numerator as is (quotient bit for 1.0)
    assign trial = (step_reg == '0) ? rem_reg : {rem_reg[W-1:0], 1'b0};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = {1'b0, num};
            den_next  = den;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? (trial - {1'b0, den_reg}) : trial;
            quo_next  = {quo_reg[QUO_W-2:0], ge};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(QUO_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

>>> dv/inversion_disorder_classifier_tb.sv
// inversion_disorder_classifier_tb: self-checking bench for the inversion disorder classifier
// streams signed lists, predicts inversion count, pair count, Q1.16 ratio, class and drop flag
// depends on idc_pkg and inversion_disorder_classifier
`timescale 1ns / 1ps

module inversion_disorder_classifier_tb;
    import idc_pkg::*;

    localparam int LIST_DEPTH = 1024;
    localparam int RANDOM_ITEMS = 580;
    localparam int SETTLE_CYCLES = 40;

    typedef enum int {
        SHAPE_RISING,
        SHAPE_FALLING,
        SHAPE_SHUFFLED,
        SHAPE_NEAR_SORTED,
        SHAPE_FEW_VALUES
    } list_shape_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         item_valid = 1'b0;
    logic         item_stall;
    item_word_t   item = '0;
    logic         result_valid;
    logic         result_stall = 1'b0;
    result_word_t result;

    class disorder_grader;
        int              seen_vals[LIST_DEPTH];
        int unsigned     seen_len;
        longint unsigned inv_running;
        bit              dropped_any;
        result_word_t    expected_grades[$];
        int unsigned     errors;

        function int unsigned pending();
            return expected_grades.size();
        endfunction

        function void note_word(item_word_t w);
            int              v;
            longint unsigned pairs;
            result_word_t    g;
            v = w.value;
            if (seen_len < LIST_DEPTH) begin
                for (int i = 0; i < seen_len; i++)
                    if (seen_vals[i] > v)
                        inv_running++;
                seen_vals[seen_len] = v;
                seen_len++;
            end
            else begin
                dropped_any = 1'b1;
            end
            if (w.is_last) begin
                pairs = seen_len;
                pairs = (pairs > 1) ? pairs * (pairs - 1) / 2 : 0;
                g.inversion_count = CNT_OUT_W'(inv_running);
                g.pair_count      = CNT_OUT_W'(pairs);
                g.disorder_q16    = (pairs == 0) ? '0 : QUO_W'((inv_running << 16) / pairs);
                // exact thresholds: 5*inv < pairs is below 0.2, 2*inv < pairs below 0.5
                if (pairs == 0 || inv_running * 5 < pairs)
                    g.disorder_class = CLASS_LOW;
                else if (inv_running * 2 < pairs)
                    g.disorder_class = CLASS_MID;
                else
                    g.disorder_class = CLASS_HIGH;
                g.overflowed = dropped_any;
                expected_grades.push_back(g);
                seen_len    = 0;
                inv_running = 0;
                dropped_any = 1'b0;
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_grade(result_word_t r);
            result_word_t g;
            if (expected_grades.size() == 0) begin
                $display("%0t: result word with nothing expected, expected none, actual %p",
                         $time, r);
                errors++;
                return;
            end
            g = expected_grades.pop_front();
            compare_field("inversion_count", g.inversion_count, r.inversion_count);
            compare_field("pair_count", g.pair_count, r.pair_count);
            compare_field("disorder_q16", g.disorder_q16, r.disorder_q16);
            compare_field("disorder_class", g.disorder_class, r.disorder_class);
            compare_field("overflowed", g.overflowed, r.overflowed);
        endfunction
    endclass

    disorder_grader grader = new;

    int burst_left = 0;
    int stall_mode = 0;
    int stall_span = 0;
    int stall_phase = 0;

    inversion_disorder_classifier #(
        .MAX_N(LIST_DEPTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && item_valid && !item_stall)
            grader.note_word(item);
        if (rst_n && result_valid && !result_stall)
            grader.check_grade(result);
    end

    // receiver stall pattern: modes of random length, free, coin toss, periodic, sparse
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            result_stall <= 1'b0;
        end
        else begin
            if (stall_span == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_span = $urandom_range(16, 200);
            end
            else begin
                stall_span--;
            end
            stall_phase = (stall_phase + 1) % 5;
            case (stall_mode)
                0: result_stall <= 1'b0;
                1: result_stall <= ($urandom_range(0, 1) == 1);
                2: result_stall <= (stall_phase < 3);
                default: result_stall <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    task automatic push_word(input int v, input bit last);
        item_word_t w;
        int         gap;
        w.value   = v;
        w.is_last = last;
        item       <= w;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        // word taken at this edge; maybe end the burst
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        else begin
            burst_left--;
        end
    endtask

    task automatic send_series(input int vals[$]);
        for (int i = 0; i < vals.size(); i++)
            push_word(vals[i], i == vals.size() - 1);
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (grader.pending() != 0)
            @(posedge clk);
    endtask

    task automatic send_random_list(input int unsigned len);
        int          series[$];
        list_shape_t shape;
        int          cur;
        int          a;
        int          b;
        int          tmp;
        shape = list_shape_t'($urandom_range(0, 4));
        cur = int'($urandom) >>> 1;
        for (int i = 0; i < len; i++) begin
            case (shape)
                SHAPE_SHUFFLED:
                    series.push_back(int'($urandom));
                SHAPE_FEW_VALUES:
                    case ($urandom_range(0, 3))
                        0: series.push_back(int'(32'h8000_0000));
                        1: series.push_back(-1);
                        2: series.push_back(0);
                        default: series.push_back(int'(32'h7fff_ffff));
                    endcase
                default: begin
                    if (shape == SHAPE_FALLING)
                        series.push_front(cur);
                    else
                        series.push_back(cur);
                    // zero steps leave runs of equal values
                    cur += ($urandom_range(0, 4) == 0) ? 0 : int'($urandom_range(1, 1 << 22));
                end
            endcase
        end
        if (shape == SHAPE_NEAR_SORTED && len > 1) begin
            repeat ($urandom_range(1, 2)) begin
                a = $urandom_range(0, len - 1);
                b = $urandom_range(0, len - 1);
                tmp = series[a];
                series[a] = series[b];
                series[b] = tmp;
            end
        end
        send_series(series);
    endtask

    initial
    begin
        int          series[$];
        int unsigned sent_random;
        int unsigned len;
        int unsigned r;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // short lists, equal values, exact class boundaries, field extremes
        series = '{int'(32'h8000_0000)};
        send_series(series);
        series = '{int'(32'h7fff_ffff), int'(32'h8000_0000)};
        send_series(series);
        series = '{-1, -1};
        send_series(series);
        series = '{5, 5, 5, 3};
        send_series(series);
        series = '{2, 1, 3, 5, 4};
        send_series(series);
        series = '{int'(32'h8000_0000), -1, 0, 1, 3, int'(32'h7fff_ffff)};
        send_series(series);
        drain_results();

        // full store: strictly falling list, then two dropped words, last one marked
        for (int i = 0; i < LIST_DEPTH + 2; i++)
            push_word(int'(32'h7fff_ffff) - i * 1000000, i == LIST_DEPTH + 1);
        drain_results();

        sent_random = 0;
        while (sent_random < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 8)
                len = 1;
            else if (r < 78)
                len = $urandom_range(2, 12);
            else if (r < 96)
                len = $urandom_range(13, 40);
            else
                len = $urandom_range(41, 120);
            send_random_list(len);
            sent_random += len;
            if ($urandom_range(0, 15) == 0)
                drain_results();
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (grader.errors == 0 && grader.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
